// ===== hdl/blcs_pkg.sv =====
// ----------------------------------------------------------------------------
// blcs_pkg: shared types and constants
// Statement codes, error codes, stack sizes and the decoded command word that
// passes from the front end to the executing back end.
// ----------------------------------------------------------------------------
package blcs_pkg;

  localparam int FOR_DEPTH    = 15;
  localparam int REPEAT_DEPTH = 16;
  localparam int WHILE_DEPTH  = 16;
  localparam int LINE_BITS    = 16;
  localparam int VALUE_BITS   = 32;
  localparam int FOR_CW = $clog2(FOR_DEPTH + 1);
  localparam int REP_CW = $clog2(REPEAT_DEPTH + 1);
  localparam int WHL_CW = $clog2(WHILE_DEPTH + 1);
  localparam int FOR_AW = (FOR_DEPTH > 1) ? $clog2(FOR_DEPTH) : 1;
  localparam int REP_AW = (REPEAT_DEPTH > 1) ? $clog2(REPEAT_DEPTH) : 1;
  localparam int WHL_AW = (WHILE_DEPTH > 1) ? $clog2(WHILE_DEPTH) : 1;

  // Q16.16 one.
  localparam logic signed [VALUE_BITS-1:0] Q_ONE = VALUE_BITS'(32'h0001_0000);

  localparam logic [2:0] MODE_FOR    = 3'd0;
  localparam logic [2:0] MODE_NEXT   = 3'd1;
  localparam logic [2:0] MODE_REPEAT = 3'd2;
  localparam logic [2:0] MODE_UNTIL  = 3'd3;
  localparam logic [2:0] MODE_WHILE  = 3'd4;
  localparam logic [2:0] MODE_WEND   = 3'd5;

  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_FOR_FULL  = 3'd1;
  localparam logic [2:0] ERR_NO_FOR    = 3'd2;
  localparam logic [2:0] ERR_MISMATCH  = 3'd3;
  localparam logic [2:0] ERR_NO_REPEAT = 3'd4;
  localparam logic [2:0] ERR_NO_WHILE  = 3'd5;
  localparam logic [2:0] ERR_FULL      = 3'd6;

  // Decoded statement handed to the back end.
  typedef struct packed {
    logic                         is_for;
    logic                         is_next;
    logic                         is_repeat;
    logic                         is_until;
    logic                         is_while;
    logic                         is_wend;
    logic                         cond;
    logic [LINE_BITS-1:0]         line_number;
    logic [7:0]                   var_id;
    logic signed [VALUE_BITS-1:0] value_a;
    logic signed [VALUE_BITS-1:0] end_value;
    logic signed [VALUE_BITS-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic                         jump;
    logic [LINE_BITS-1:0]         next_line;
    logic                         write_var;
    logic signed [VALUE_BITS-1:0] var_value;
    logic                         skip_body;
    logic [2:0]                   error_code;
  } res_t;

endpackage

// ===== hdl/blcs_front.sv =====
// ----------------------------------------------------------------------------
// blcs_front: statement decoder
// Accepts input words, decodes the statement kind and the default step, and
// pushes one command per word into a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module blcs_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [2:0]                           mode,
  input  logic [blcs_pkg::LINE_BITS-1:0]       line_number,
  input  logic [7:0]                           var_id,
  input  logic signed [blcs_pkg::VALUE_BITS-1:0] value_a,
  input  logic signed [blcs_pkg::VALUE_BITS-1:0] end_value,
  input  logic signed [blcs_pkg::VALUE_BITS-1:0] step_value,
  input  logic                                 step_given,
  output logic                                 cmd_valid,
  input  logic                                 cmd_ready,
  output blcs_pkg::cmd_t                       cmd
);

  blcs_pkg::cmd_t q [2];
  logic           wr_ptr, rd_ptr;
  logic [1:0]     fill;
  blcs_pkg::cmd_t dec;
  logic           push, pop;

  // Decode one statement word.
  always_comb begin
    dec             = '0;
    dec.is_for      = (mode == blcs_pkg::MODE_FOR);
    dec.is_next     = (mode == blcs_pkg::MODE_NEXT);
    dec.is_repeat   = (mode == blcs_pkg::MODE_REPEAT);
    dec.is_until    = (mode == blcs_pkg::MODE_UNTIL);
    dec.is_while    = (mode == blcs_pkg::MODE_WHILE);
    dec.is_wend     = (mode == blcs_pkg::MODE_WEND);
    dec.cond        = (value_a != '0);
    dec.line_number = line_number;
    dec.var_id      = var_id;
    dec.value_a     = value_a;
    dec.end_value   = end_value;
    dec.step        = step_given ? step_value : blcs_pkg::Q_ONE;
  end

  assign in_ready  = (fill != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (fill != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= dec;
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== hdl/blcs_back.sv =====
// ----------------------------------------------------------------------------
// blcs_back: stack executor
// Executes one command per cycle while the result is not stalled, against
// the three loop stacks, and registers the result word in an output stage.
// ----------------------------------------------------------------------------
module blcs_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  blcs_pkg::cmd_t     cmd,
  output logic               res_valid,
  input  logic               res_ready,
  output blcs_pkg::res_t     res
);

  logic [7:0]                            for_var       [blcs_pkg::FOR_DEPTH];
  logic signed [blcs_pkg::VALUE_BITS-1:0] for_limit    [blcs_pkg::FOR_DEPTH];
  logic signed [blcs_pkg::VALUE_BITS-1:0] for_increment [blcs_pkg::FOR_DEPTH];
  logic [blcs_pkg::LINE_BITS-1:0]        for_line      [blcs_pkg::FOR_DEPTH];
  logic [blcs_pkg::LINE_BITS-1:0]        repeat_lines  [blcs_pkg::REPEAT_DEPTH];
  logic [blcs_pkg::LINE_BITS-1:0]        while_lines   [blcs_pkg::WHILE_DEPTH];

  logic [blcs_pkg::FOR_CW-1:0] for_count, for_count_next;
  logic [blcs_pkg::REP_CW-1:0] repeat_count, repeat_count_next;
  logic [blcs_pkg::WHL_CW-1:0] while_count, while_count_next;

  logic [blcs_pkg::FOR_AW-1:0] for_top, for_wa;
  logic [blcs_pkg::REP_AW-1:0] rep_top, rep_wa;
  logic [blcs_pkg::WHL_AW-1:0] whl_top, whl_wa;

  logic go, for_push, rep_push, whl_push;
  blcs_pkg::res_t r;
  logic signed [blcs_pkg::VALUE_BITS:0] sum;
  logic signed [blcs_pkg::VALUE_BITS-1:0] nv, inc, lim;
  logic done;

  assign cmd_ready = !res_valid || res_ready;
  assign go        = cmd_valid && cmd_ready;

  assign for_top = blcs_pkg::FOR_AW'(for_count - 1'b1);
  assign rep_top = blcs_pkg::REP_AW'(repeat_count - 1'b1);
  assign whl_top = blcs_pkg::WHL_AW'(while_count - 1'b1);
  assign for_wa  = blcs_pkg::FOR_AW'(for_count);
  assign rep_wa  = blcs_pkg::REP_AW'(repeat_count);
  assign whl_wa  = blcs_pkg::WHL_AW'(while_count);

  // Saturating add of the step to the current value, and the exit test.
  always_comb begin
    inc = for_increment[for_top];
    lim = for_limit[for_top];
    sum = {cmd.value_a[blcs_pkg::VALUE_BITS-1], cmd.value_a} +
          {inc[blcs_pkg::VALUE_BITS-1], inc};
    if (sum[blcs_pkg::VALUE_BITS] != sum[blcs_pkg::VALUE_BITS-1])
      nv = sum[blcs_pkg::VALUE_BITS] ? {1'b1, {(blcs_pkg::VALUE_BITS-1){1'b0}}}
                                     : {1'b0, {(blcs_pkg::VALUE_BITS-1){1'b1}}};
    else
      nv = sum[blcs_pkg::VALUE_BITS-1:0];
    done = (inc > 0) ? (nv > lim) : (nv < lim);
  end

  // Statement execution.
  always_comb begin
    r                 = '0;
    for_count_next    = for_count;
    repeat_count_next = repeat_count;
    while_count_next  = while_count;
    for_push = 1'b0;
    rep_push = 1'b0;
    whl_push = 1'b0;
    priority if (cmd.is_for) begin
      if (for_count >= blcs_pkg::FOR_CW'(blcs_pkg::FOR_DEPTH)) begin
        r.error_code = blcs_pkg::ERR_FOR_FULL;
      end else begin
        r.write_var    = 1'b1;
        r.var_value    = cmd.value_a;
        for_push       = 1'b1;
        for_count_next = for_count + 1'b1;
      end
    end else if (cmd.is_next) begin
      if (for_count == '0) begin
        r.error_code = blcs_pkg::ERR_NO_FOR;
      end else if (for_var[for_top] != cmd.var_id) begin
        r.error_code = blcs_pkg::ERR_MISMATCH;
      end else begin
        r.write_var = 1'b1;
        r.var_value = nv;
        if (done) begin
          for_count_next = for_count - 1'b1;
        end else begin
          r.jump      = 1'b1;
          r.next_line = for_line[for_top];
        end
      end
    end else if (cmd.is_repeat) begin
      if (repeat_count >= blcs_pkg::REP_CW'(blcs_pkg::REPEAT_DEPTH)) begin
        r.error_code = blcs_pkg::ERR_FULL;
      end else begin
        rep_push          = 1'b1;
        repeat_count_next = repeat_count + 1'b1;
      end
    end else if (cmd.is_until) begin
      if (repeat_count == '0) begin
        r.error_code = blcs_pkg::ERR_NO_REPEAT;
      end else if (!cmd.cond) begin
        r.jump      = 1'b1;
        r.next_line = repeat_lines[rep_top];
      end else begin
        repeat_count_next = repeat_count - 1'b1;
      end
    end else if (cmd.is_while) begin
      if (!cmd.cond) begin
        r.skip_body = 1'b1;
      end else if (while_count >= blcs_pkg::WHL_CW'(blcs_pkg::WHILE_DEPTH)) begin
        r.error_code = blcs_pkg::ERR_FULL;
      end else begin
        whl_push         = 1'b1;
        while_count_next = while_count + 1'b1;
      end
    end else if (cmd.is_wend) begin
      if (while_count == '0) begin
        r.error_code = blcs_pkg::ERR_NO_WHILE;
      end else if (cmd.cond) begin
        r.jump      = 1'b1;
        r.next_line = while_lines[whl_top];
      end else begin
        while_count_next = while_count - 1'b1;
      end
    end else begin
      r = '0;
    end
  end

  // Stack storage.
  always_ff @(posedge clk) begin
    if (go && for_push) begin
      for_var[for_wa]       <= cmd.var_id;
      for_limit[for_wa]     <= cmd.end_value;
      for_increment[for_wa] <= cmd.step;
      for_line[for_wa]      <= cmd.line_number;
    end
    if (go && rep_push) repeat_lines[rep_wa] <= cmd.line_number;
    if (go && whl_push) while_lines[whl_wa] <= cmd.line_number;
  end

  // Stack depths and output stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      for_count    <= '0;
      repeat_count <= '0;
      while_count  <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (go) begin
        for_count    <= for_count_next;
        repeat_count <= repeat_count_next;
        while_count  <= while_count_next;
        res_valid    <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) res <= r;
  end

endmodule

// ===== hdl/basic_loop_control_stack_unit.sv =====
// ----------------------------------------------------------------------------
// basic_loop_control_stack_unit: BASIC loop control
// FOR/NEXT, REPEAT/UNTIL and WHILE/WEND execution with three stacks.
// ----------------------------------------------------------------------------
// Each input word is one statement and yields exactly one result word. A
// decoder stage writes each accepted word into a two-entry queue; the executor
// takes one statement per cycle while the result is not stalled, so the
// sustained rate is then one word per cycle. The result word is registered
// first in the queue entry and then in the result register. A stalled result
// holds the executor and, once the queue is full, the input. Stacks need no
// clearing after reset.
module basic_loop_control_stack_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata: mode[2:0], line_number[18:3], var_id[26:19], value_a[58:27],
  // end_value[90:59], step_value[122:91], step_given[123], zero fill
  input  logic [127:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata: jump[0], next_line[16:1], write_var[17], var_value[49:18],
  // skip_body[50], error_code[53:51], zero fill
  output logic [55:0]  m_tdata
);

  logic           cmd_valid, cmd_ready;
  blcs_pkg::cmd_t cmd;
  blcs_pkg::res_t res;

  blcs_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .mode(s_tdata[2:0]), .line_number(s_tdata[18:3]), .var_id(s_tdata[26:19]),
    .value_a(s_tdata[58:27]), .end_value(s_tdata[90:59]),
    .step_value(s_tdata[122:91]), .step_given(s_tdata[123]),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  blcs_back u_back (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .res_valid(m_tvalid), .res_ready(m_tready), .res(res)
  );

  assign m_tdata = {2'b00, res.error_code, res.skip_body, res.var_value,
                    res.write_var, res.next_line, res.jump};

endmodule

// ===== hdl/blcs_checker.sv =====
// ----------------------------------------------------------------------------
// blcs_checker: port-level checks
// Watches the stream ports of the loop-control unit.
// ----------------------------------------------------------------------------
module blcs_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [55:0]  m_tdata
);

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // No result right after reset.
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Error words carry no jump and no write.
  a_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[53:51] != blcs_pkg::ERR_OK |-> !m_tdata[0] && !m_tdata[17])
    else $error("error word with side effects");

  // A result that rises needs an input word accepted before it.
  a_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2) || $past(s_tvalid && s_tready))
    else $error("result without input");

endmodule

bind basic_loop_control_stack_unit blcs_checker u_blcs_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: loop-control unit stack and result check
// Drives FOR/NEXT, REPEAT/UNTIL and WHILE/WEND statements into the unit with
// random gaps on both sides, tracks the three loop stacks alongside it and
// compares every result word field by field against the tracked behavior.
// ----------------------------------------------------------------------------
module tb;

  // Statement codes with no meaning; the unit ignores them.
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  typedef struct packed {
    logic                                   step_given;
    logic signed [blcs_pkg::VALUE_BITS-1:0] step_value;
    logic signed [blcs_pkg::VALUE_BITS-1:0] end_value;
    logic signed [blcs_pkg::VALUE_BITS-1:0] value_a;
    logic [7:0]                             var_id;
    logic [blcs_pkg::LINE_BITS-1:0]         line_number;
    logic [2:0]                             mode;
  } stmt_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [55:0]  m_tdata;

  stmt_t          stmt_q[$];
  blcs_pkg::res_t loop_result_q[$];
  int    mismatches = 0;
  bit    hold_sender = 1'b0;
  int    send_gap = 0;
  int    recv_gap = 0;

  // Tracked loop stacks.
  logic [7:0]                             fv[blcs_pkg::FOR_DEPTH];
  logic signed [blcs_pkg::VALUE_BITS-1:0] flim[blcs_pkg::FOR_DEPTH];
  logic signed [blcs_pkg::VALUE_BITS-1:0] finc[blcs_pkg::FOR_DEPTH];
  logic [blcs_pkg::LINE_BITS-1:0]         fln[blcs_pkg::FOR_DEPTH];
  logic [blcs_pkg::LINE_BITS-1:0]         rep_ln[blcs_pkg::REPEAT_DEPTH];
  logic [blcs_pkg::LINE_BITS-1:0]         whl_ln[blcs_pkg::WHILE_DEPTH];
  int fcnt = 0, rcnt = 0, wcnt = 0;

  basic_loop_control_stack_unit uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Executes one statement on the tracked stacks and returns its result.
  function automatic blcs_pkg::res_t run_statement(stmt_t s);
    blcs_pkg::res_t r;
    logic signed [blcs_pkg::VALUE_BITS-1:0] inc, nv;
    logic signed [blcs_pkg::VALUE_BITS:0] wide;
    bit done;
    r = '0;
    unique case (s.mode)
      blcs_pkg::MODE_FOR: begin
        if (fcnt >= blcs_pkg::FOR_DEPTH) r.error_code = blcs_pkg::ERR_FOR_FULL;
        else begin
          r.write_var = 1'b1;
          r.var_value = s.value_a;
          fv[fcnt] = s.var_id;
          flim[fcnt] = s.end_value;
          finc[fcnt] = s.step_given ? s.step_value : blcs_pkg::Q_ONE;
          fln[fcnt] = s.line_number;
          fcnt++;
        end
      end
      blcs_pkg::MODE_NEXT: begin
        if (fcnt == 0) r.error_code = blcs_pkg::ERR_NO_FOR;
        else if (fv[fcnt-1] != s.var_id) r.error_code = blcs_pkg::ERR_MISMATCH;
        else begin
          inc = finc[fcnt-1];
          wide = $signed({s.value_a[blcs_pkg::VALUE_BITS-1], s.value_a}) +
                 $signed({inc[blcs_pkg::VALUE_BITS-1], inc});
          if (wide[blcs_pkg::VALUE_BITS] != wide[blcs_pkg::VALUE_BITS-1])
            nv = wide[blcs_pkg::VALUE_BITS] ?
                 {1'b1, {(blcs_pkg::VALUE_BITS-1){1'b0}}} :
                 {1'b0, {(blcs_pkg::VALUE_BITS-1){1'b1}}};
          else nv = wide[blcs_pkg::VALUE_BITS-1:0];
          done = (inc > 0) ? (nv > flim[fcnt-1]) : (nv < flim[fcnt-1]);
          r.write_var = 1'b1;
          r.var_value = nv;
          if (done) fcnt--;
          else begin
            r.jump = 1'b1;
            r.next_line = fln[fcnt-1];
          end
        end
      end
      blcs_pkg::MODE_REPEAT: begin
        if (rcnt >= blcs_pkg::REPEAT_DEPTH) r.error_code = blcs_pkg::ERR_FULL;
        else begin
          rep_ln[rcnt] = s.line_number;
          rcnt++;
        end
      end
      blcs_pkg::MODE_UNTIL: begin
        if (rcnt == 0) r.error_code = blcs_pkg::ERR_NO_REPEAT;
        else if (s.value_a == 0) begin
          r.jump = 1'b1;
          r.next_line = rep_ln[rcnt-1];
        end else rcnt--;
      end
      blcs_pkg::MODE_WHILE: begin
        if (s.value_a == 0) r.skip_body = 1'b1;
        else if (wcnt >= blcs_pkg::WHILE_DEPTH) r.error_code = blcs_pkg::ERR_FULL;
        else begin
          whl_ln[wcnt] = s.line_number;
          wcnt++;
        end
      end
      blcs_pkg::MODE_WEND: begin
        if (wcnt == 0) r.error_code = blcs_pkg::ERR_NO_WHILE;
        else if (s.value_a != 0) begin
          r.jump = 1'b1;
          r.next_line = whl_ln[wcnt-1];
        end else wcnt--;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("error: %s got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Appends one statement to the pending queue.
  function automatic void add_stmt(stmt_t s);
    stmt_q.insert(stmt_q.size(), s);
  endfunction

  // Driver: presents queued statements with random gaps.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        loop_result_q.insert(loop_result_q.size(),
                             run_statement(stmt_t'(s_tdata[123:0])));
        send_gap = pick_gap();
      end
      if ((!s_tvalid || s_tready) && !(s_tvalid && !s_tready)) begin
        if (send_gap == 0 && stmt_q.size() > 0 && !hold_sender) begin
          s_tdata <= {4'b0, stmt_q.pop_front()};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end
      end
    end
  end

  // Monitor: random stall on the result side, compare each accepted word.
  always @(posedge clk) begin
    blcs_pkg::res_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.jump       = m_tdata[0];
        got.next_line  = m_tdata[16:1];
        got.write_var  = m_tdata[17];
        got.var_value  = m_tdata[49:18];
        got.skip_body  = m_tdata[50];
        got.error_code = m_tdata[53:51];
        if (m_tdata[55:54] != 2'b0) report("fill", 64'(m_tdata[55:54]), 64'd0);
        if (loop_result_q.size() == 0) report("unexpected word", 64'(m_tdata), 64'd0);
        else begin
          want = loop_result_q.pop_front();
          if (got.jump != want.jump) report("jump", 64'(got.jump), 64'(want.jump));
          if (got.next_line != want.next_line)
            report("next_line", 64'(got.next_line), 64'(want.next_line));
          if (got.write_var != want.write_var)
            report("write_var", 64'(got.write_var), 64'(want.write_var));
          if (got.var_value != want.var_value)
            report("var_value", 64'(got.var_value), 64'(want.var_value));
          if (got.skip_body != want.skip_body)
            report("skip_body", 64'(got.skip_body), 64'(want.skip_body));
          if (got.error_code != want.error_code)
            report("error_code", 64'(got.error_code), 64'(want.error_code));
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        recv_gap = pick_gap();
        m_tready <= 1'b0;
      end else m_tready <= 1'b1;
    end
  end

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return 0;
      3: return $signed($urandom_range(0, 8) << 16);
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic stmt_t mk(logic [2:0] m, logic [15:0] ln, logic [7:0] v,
                               logic signed [31:0] a, logic signed [31:0] e,
                               logic signed [31:0] st, logic sg);
    stmt_t s;
    s.mode = m; s.line_number = ln; s.var_id = v; s.value_a = a;
    s.end_value = e; s.step_value = st; s.step_given = sg;
    return s;
  endfunction

  // Random statement: mostly loop-shaped, with some noise.
  function automatic stmt_t rand_stmt(ref logic [7:0] cur_var);
    stmt_t s;
    s = stmt_t'(124'({$urandom(), $urandom(), $urandom(), $urandom()}));
    s.value_a = rand_value();
    s.end_value = rand_value();
    s.step_value = ($urandom_range(0, 1)) ? rand_value()
                                          : $signed($urandom_range(0, 4) << 15);
    s.mode = 3'($urandom_range(0, 17) / 3);
    if ($urandom_range(0, 30) == 0)
      s.mode = $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
    if (s.mode == blcs_pkg::MODE_FOR) cur_var = s.var_id;
    if (s.mode == blcs_pkg::MODE_NEXT && $urandom_range(0, 4) != 0) s.var_id = cur_var;
    if (s.mode != blcs_pkg::MODE_FOR && s.mode != blcs_pkg::MODE_NEXT &&
        $urandom_range(0, 1))
      s.value_a = $urandom_range(0, 1) ? 0 : 32'sh0001_0000;
    return s;
  endfunction

  initial begin
    logic [7:0] cur_var;
    cur_var = 8'h00;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // Directed: empty-stack errors, unused codes, extremes, saturation.
    add_stmt(mk(blcs_pkg::MODE_NEXT, 16'd1, 8'd0, 0, 0, 0, 1'b0));
    add_stmt(mk(blcs_pkg::MODE_UNTIL, 16'd2, 8'd0, 0, 0, 0, 1'b0));
    add_stmt(mk(blcs_pkg::MODE_WEND, 16'd3, 8'd0, 1, 0, 0, 1'b0));
    add_stmt(mk(MODE_SPARE_LO, 16'hffff, 8'hff, -1, -1, -1, 1'b1));
    add_stmt(mk(MODE_SPARE_HI, 16'hffff, 8'hff, -1, -1, -1, 1'b1));
    add_stmt(mk(blcs_pkg::MODE_FOR, 16'hffff, 8'hff, 32'sh7fff_0000,
                32'sh7fff_ffff, 32'sh7fff_ffff, 1'b1));
    add_stmt(mk(blcs_pkg::MODE_NEXT, 16'd9, 8'h00, 0, 0, 0, 1'b0));
    add_stmt(mk(blcs_pkg::MODE_NEXT, 16'd9, 8'hff, 32'sh7fff_0000, 0, 0, 1'b0));
    add_stmt(mk(blcs_pkg::MODE_FOR, 16'd10, 8'd5, 32'sh8000_0000,
                32'sh8000_0000, 32'sh8000_0000, 1'b1));
    add_stmt(mk(blcs_pkg::MODE_NEXT, 16'd11, 8'd5, 32'sh8000_0000, 0, 0, 1'b0));
    add_stmt(mk(blcs_pkg::MODE_FOR, 16'd12, 8'd7, 0, 32'sh0001_0000, 0, 1'b0));
    add_stmt(mk(blcs_pkg::MODE_NEXT, 16'd13, 8'd7, 0, 0, 0, 1'b0));
    add_stmt(mk(blcs_pkg::MODE_NEXT, 16'd13, 8'd7, 32'sh0001_0000, 0, 0, 1'b0));
    add_stmt(mk(blcs_pkg::MODE_FOR, 16'd14, 8'd8, 0, 0, 0, 1'b1));
    add_stmt(mk(blcs_pkg::MODE_NEXT, 16'd15, 8'd8, 0, 0, 0, 1'b0));
    add_stmt(mk(blcs_pkg::MODE_REPEAT, 16'h8000, 8'd0, 0, 0, 0, 1'b0));
    add_stmt(mk(blcs_pkg::MODE_UNTIL, 16'd17, 8'd0, 0, 0, 0, 1'b0));
    add_stmt(mk(blcs_pkg::MODE_UNTIL, 16'd17, 8'd0, -1, 0, 0, 1'b0));
    add_stmt(mk(blcs_pkg::MODE_WHILE, 16'd18, 8'd0, 0, 0, 0, 1'b0));
    add_stmt(mk(blcs_pkg::MODE_WHILE, 16'h7fff, 8'd0, 1, 0, 0, 1'b0));
    add_stmt(mk(blcs_pkg::MODE_WEND, 16'd19, 8'd0, 1, 0, 0, 1'b0));
    add_stmt(mk(blcs_pkg::MODE_WEND, 16'd19, 8'd0, 0, 0, 0, 1'b0));
    // Fill every stack past full.
    repeat (17) begin
      add_stmt(mk(blcs_pkg::MODE_FOR, 16'($urandom()), 8'd3, 0, 0, 0, 1'b1));
      add_stmt(mk(blcs_pkg::MODE_REPEAT, 16'($urandom()), 8'd0, 0, 0, 0, 1'b0));
      add_stmt(mk(blcs_pkg::MODE_WHILE, 16'($urandom()), 8'd0, 1, 0, 0, 1'b0));
    end
    repeat (17) begin
      add_stmt(mk(blcs_pkg::MODE_NEXT, 16'd0, 8'd3, 0, 0, 0, 1'b0));
      add_stmt(mk(blcs_pkg::MODE_UNTIL, 16'd0, 8'd0, 1, 0, 0, 1'b0));
      add_stmt(mk(blcs_pkg::MODE_WEND, 16'd0, 8'd0, 0, 0, 0, 1'b0));
    end
    repeat (215) add_stmt(rand_stmt(cur_var));
    // Hold the sender with statements pending until every result has drained.
    wait (stmt_q.size() < 60);
    @(negedge clk);
    hold_sender = 1'b1;
    while (s_tvalid || loop_result_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    hold_sender = 1'b0;
    repeat (215) add_stmt(rand_stmt(cur_var));
    while (stmt_q.size() != 0 || s_tvalid || loop_result_q.size() != 0)
      @(negedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== basic_loop_control_stack_unit.f =====
hdl/blcs_pkg.sv
hdl/blcs_front.sv
hdl/blcs_back.sv
hdl/basic_loop_control_stack_unit.sv
hdl/blcs_checker.sv
tb/tb.sv
